// File: rtl/core/rule_image_transition_blend_top_defines.svh
// Assertion macros shared by the blend block.
`ifndef RULE_IMAGE_TRANSITION_BLEND_TOP_DEFINES_SVH
`define RULE_IMAGE_TRANSITION_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define RTB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define RTB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rtb_pkg.sv
// Types and constants of the rule image transition blender.
package rtb_pkg;

    localparam int unsigned PIX_W     = 32;
    localparam int unsigned LVL_W     = 8;
    localparam int unsigned THR_W     = 9;
    localparam int unsigned FACTOR_W  = 16;
    localparam int unsigned TBL_DEPTH = 256;
    localparam int unsigned TBL_AW    = 8;
    localparam int unsigned CH_N      = 4;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned SLICE_W   = 15;  // product bits 30..16

    // s_tdata layout, lowest bit first
    localparam int unsigned TD_LINE   = 0;
    localparam int unsigned TD_A_LO   = 1;
    localparam int unsigned TD_B_LO   = TD_A_LO + PIX_W;
    localparam int unsigned TD_CUR_LO = TD_B_LO + PIX_W;
    localparam int unsigned TD_NXT_LO = TD_CUR_LO + LVL_W;
    localparam int unsigned TD_IDX_LO = TD_NXT_LO + LVL_W;
    localparam int unsigned TD_VAL_LO = TD_IDX_LO + TBL_AW;
    localparam int unsigned TD_USED   = TD_VAL_LO + FACTOR_W;
    localparam int unsigned S_TDATA_W = ((TD_USED + 7) / 8) * 8;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEVEL = 2'd2;

    localparam logic ACT_BLEND = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [THR_W-1:0] FIRST_LEVEL_RST  = 9'd256;
    localparam logic [THR_W-1:0] SECOND_LEVEL_RST = 9'd0;

    typedef enum logic [1:0] {
        SEL_BLEND  = 2'd0,
        SEL_FIRST  = 2'd1,
        SEL_SECOND = 2'd2
    } sel_t;

    typedef enum logic [2:0] {
        PEND_NONE   = 3'b001,
        PEND_FIRST  = 3'b010,
        PEND_SECOND = 3'b100
    } pend_t;

    typedef struct packed {
        logic             switch_mode;
        logic [THR_W-1:0] first_level;
        logic [THR_W-1:0] second_level;
    } cfg_t;

    typedef struct packed {
        logic             line_start;
        logic [LVL_W-1:0] cur;
        logic [LVL_W-1:0] nxt;
    } lvl_t;

endpackage

// File: rtl/core/rule_image_transition_blend_top.sv
// Pipeline: a request passes stage 1, stage 2 and the output register (3 stages) to m_tdata.
// Throughput: one request per cycle unless m_tready stalls the output; the factor
// table RAM reads and writes once a cycle; channel multipliers are fully pipelined.
// Table write requests give no result and take one slot at the input only.
// Reset (aresetn low, synchronous) empties the pipeline, restores the config
// registers and the switching state; the factor table is not cleared.
`include "rule_image_transition_blend_top_defines.svh"

module rule_image_transition_blend_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // line_start, first_pixel, second_pixel, rule_level, next_rule_level,
    // table_index, table_value, zero padding
    input  logic [rtb_pkg::S_TDATA_W-1:0]         s_tdata,
    // action
    input  logic                                  s_tuser,
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // blended_pixel
    output logic [rtb_pkg::PIX_W-1:0]             m_tdata,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [rtb_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [rtb_pkg::THR_W-1:0]             cfg_wr_data
);

    // --- configuration registers ------------------------------------------
    rtb_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.switch_mode  <= 1'b0;
            cfg_reg.first_level  <= rtb_pkg::FIRST_LEVEL_RST;
            cfg_reg.second_level <= rtb_pkg::SECOND_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                rtb_pkg::CFG_SWITCH_MODE:  cfg_reg.switch_mode  <= cfg_wr_data[0];
                rtb_pkg::CFG_FIRST_LEVEL:  cfg_reg.first_level  <= cfg_wr_data;
                rtb_pkg::CFG_SECOND_LEVEL: cfg_reg.second_level <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // --- input field unpacking ----------------------------------------------
    logic                             in_line;
    logic [rtb_pkg::PIX_W-1:0]        in_a, in_b;
    logic [rtb_pkg::LVL_W-1:0]        in_cur, in_nxt;
    logic [rtb_pkg::TBL_AW-1:0]       in_idx;
    logic [rtb_pkg::FACTOR_W-1:0]     in_val;

    assign in_line = s_tdata[rtb_pkg::TD_LINE];
    assign in_a    = s_tdata[rtb_pkg::TD_A_LO   +: rtb_pkg::PIX_W];
    assign in_b    = s_tdata[rtb_pkg::TD_B_LO   +: rtb_pkg::PIX_W];
    assign in_cur  = s_tdata[rtb_pkg::TD_CUR_LO +: rtb_pkg::LVL_W];
    assign in_nxt  = s_tdata[rtb_pkg::TD_NXT_LO +: rtb_pkg::LVL_W];
    assign in_idx  = s_tdata[rtb_pkg::TD_IDX_LO +: rtb_pkg::TBL_AW];
    assign in_val  = s_tdata[rtb_pkg::TD_VAL_LO +: rtb_pkg::FACTOR_W];

    // --- pipeline flow control ----------------------------------------------
    // Each stage moves when the one ahead is empty or moving, so bubbles close
    // up; while a result waits, the input takes requests until the stages fill.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_adv, s2_adv, s1_adv;
    logic s_accept, blend_accept, write_accept;

    assign out_adv      = m_tready || !m_valid_reg;
    assign s2_adv       = out_adv || !s2_valid_reg;
    assign s1_adv       = s2_adv || !s1_valid_reg;
    assign s_tready     = s1_adv;
    assign s_accept     = s_tvalid && s_tready;
    assign blend_accept = s_accept && (s_tuser == rtb_pkg::ACT_BLEND);
    assign write_accept = s_accept && (s_tuser == rtb_pkg::ACT_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= blend_accept;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // --- factor table -------------------------------------------------------
    // Read at acceptance; the read word is held in the RAM output register
    // while stage 1 stalls, since nothing else reads it then. A write lands
    // before any later request reads, so no forwarding is needed.
    logic [rtb_pkg::FACTOR_W-1:0] factor_q;

    rtb_ram #(
        .WIDTH (rtb_pkg::FACTOR_W),
        .DEPTH (rtb_pkg::TBL_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (write_accept),
        .waddr (in_idx),
        .wdata (in_val),
        .re    (blend_accept),
        .raddr (in_cur),
        .rdata (factor_q)
    );

    // --- copy/blend decision, made at acceptance ---------------------------
    rtb_pkg::lvl_t in_lvl;
    rtb_pkg::sel_t sel_now;

    assign in_lvl.line_start = in_line;
    assign in_lvl.cur        = in_cur;
    assign in_lvl.nxt        = in_nxt;

    rtb_switch u_switch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (blend_accept),
        .lvl     (in_lvl),
        .sel     (sel_now)
    );

    // --- stage 1 payload ----------------------------------------------------
    logic [rtb_pkg::PIX_W-1:0] s1_a_reg, s1_b_reg;
    rtb_pkg::sel_t             s1_sel_reg;

    always_ff @(posedge aclk) begin
        if (blend_accept) begin
            s1_a_reg   <= in_a;
            s1_b_reg   <= in_b;
            s1_sel_reg <= sel_now;
        end
    end

    // --- stage 2: multiply registered inside, finish feeds the output ------
    logic [rtb_pkg::PIX_W-1:0] mix_pixel;

    rtb_mix u_mix (
        .aclk   (aclk),
        .ld     (s2_adv && s1_valid_reg),
        .pix_a  (s1_a_reg),
        .pix_b  (s1_b_reg),
        .factor (factor_q),
        .sel    (s1_sel_reg),
        .pixel  (mix_pixel)
    );

    // --- output register ----------------------------------------------------
    logic [rtb_pkg::PIX_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (out_adv && s2_valid_reg) begin
            m_data_reg <= mix_pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // --- assertions ---------------------------------------------------------
    `RTB_ASSERT_NEXT(a_write_no_result, aclk, aresetn, write_accept, !s1_valid_reg,
        "table write request entered the result pipeline")
    `RTB_ASSERT_NEXT(a_plain_blends, aclk, aresetn,
        blend_accept && !cfg_reg.switch_mode, s1_sel_reg == rtb_pkg::SEL_BLEND,
        "plain mode request selected a copy")
    `RTB_ASSERT_NEXT(a_factor_held, aclk, aresetn, s1_valid_reg && !s2_adv,
        $stable(factor_q), "factor changed under a stalled stage 1 request")

endmodule

// File: rtl/core/rtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtb_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rtb_switch.sv
// Copy/blend switching state and per-pixel source selection.
module rtb_switch (
    input  logic               aclk,
    input  logic               aresetn,
    input  rtb_pkg::cfg_t      cfg,
    input  logic               step,
    input  rtb_pkg::lvl_t      lvl,
    output rtb_pkg::sel_t      sel
);

    logic           decide_reg, decide_next;
    rtb_pkg::pend_t pend_reg, pend_next;
    logic           ds;
    rtb_pkg::pend_t pc;
    logic           nxt_ge_first, cur_ge_first, nxt_ge_second, cur_ge_second;

    assign nxt_ge_first  = {1'b0, lvl.nxt} >= cfg.first_level;
    assign cur_ge_first  = {1'b0, lvl.cur} >= cfg.first_level;
    assign nxt_ge_second = {1'b0, lvl.nxt} >= cfg.second_level;
    assign cur_ge_second = {1'b0, lvl.cur} >= cfg.second_level;

    always_comb begin
        // line start restarts the decision in either mode
        ds          = lvl.line_start ? 1'b1 : decide_reg;
        pc          = lvl.line_start ? rtb_pkg::PEND_NONE : pend_reg;
        decide_next = ds;
        pend_next   = pc;
        sel         = rtb_pkg::SEL_BLEND;
        if (cfg.switch_mode) begin
            pend_next = rtb_pkg::PEND_NONE;
            priority if (pc == rtb_pkg::PEND_FIRST) begin
                sel = rtb_pkg::SEL_FIRST;
            end else if (pc == rtb_pkg::PEND_SECOND) begin
                sel = rtb_pkg::SEL_SECOND;
            end else if (!ds) begin
                decide_next = 1'b1;
            end else if (nxt_ge_first && !cur_ge_first) begin
                decide_next = 1'b0;
            end else if (nxt_ge_first) begin
                pend_next = rtb_pkg::PEND_FIRST;
                sel       = rtb_pkg::SEL_FIRST;
            end else if (nxt_ge_second || cur_ge_second) begin
                decide_next = 1'b0;
            end else begin
                pend_next = rtb_pkg::PEND_SECOND;
                sel       = rtb_pkg::SEL_SECOND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decide_reg <= 1'b1;
            pend_reg   <= rtb_pkg::PEND_NONE;
        end else if (step) begin
            decide_reg <= decide_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// File: rtl/core/rtb_mix.sv
// Channel multiply stage and saturating finish of the blend.
module rtb_mix (
    input  logic                             aclk,
    input  logic                             ld,
    input  logic [rtb_pkg::PIX_W-1:0]        pix_a,
    input  logic [rtb_pkg::PIX_W-1:0]        pix_b,
    input  logic [rtb_pkg::FACTOR_W-1:0]     factor,
    input  rtb_pkg::sel_t                    sel,
    output logic [rtb_pkg::PIX_W-1:0]        pixel
);

    localparam int unsigned DIFF_W = rtb_pkg::CH_W + 1;
    localparam int unsigned PROD_W = DIFF_W + rtb_pkg::FACTOR_W + 1;
    localparam int unsigned SUM_W  = rtb_pkg::SLICE_W + 1;

    logic [rtb_pkg::SLICE_W-1:0] slice_next [rtb_pkg::CH_N];
    logic [rtb_pkg::SLICE_W-1:0] slice_reg  [rtb_pkg::CH_N];
    logic [rtb_pkg::PIX_W-1:0]   a_reg, b_reg;
    rtb_pkg::sel_t               sel_reg;
    logic [rtb_pkg::PIX_W-1:0]   mixed;

    // (a - b) * f keeps only bits 30..16; the 9-bit signed difference
    // times the factor is exact in 26 bits, sign-extended above that.
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic signed [PROD_W-1:0] p;
        for (int ch = 0; ch < rtb_pkg::CH_N; ch++) begin
            d = $signed({1'b0, pix_a[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W]})
              - $signed({1'b0, pix_b[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W]});
            p = d * $signed({1'b0, factor});
            slice_next[ch] = {{(rtb_pkg::SLICE_W - (PROD_W - 16)){p[PROD_W-1]}},
                              p[PROD_W-1:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            slice_reg <= slice_next;
            a_reg     <= pix_a;
            b_reg     <= pix_b;
            sel_reg   <= sel;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] t;
        mixed = '0;
        for (int ch = 0; ch < rtb_pkg::CH_N; ch++) begin
            t = {slice_reg[ch], 1'b0}
              + {{(SUM_W - rtb_pkg::CH_W){1'b0}}, b_reg[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W]};
            if (t[SUM_W-1]) begin
                mixed[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W] = '0;
            end else if (t[SUM_W-2:rtb_pkg::CH_W] != '0) begin
                mixed[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W] = '1;
            end else begin
                mixed[ch*rtb_pkg::CH_W +: rtb_pkg::CH_W] = t[rtb_pkg::CH_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (sel_reg)
            rtb_pkg::SEL_FIRST:  pixel = a_reg;
            rtb_pkg::SEL_SECOND: pixel = b_reg;
            default:             pixel = mixed;
        endcase
    end

endmodule

// File: test/testbench.sv
// Self-checking bench for the rule image transition blender.
module testbench;
    import rtb_pkg::*;

    // Generous bound: every request waiting out the longest sender gap and
    // receiver stall, plus the drains between register settings.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles let pass once nothing is expected; the design has three stages.
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;

    // One request, field by field, at the widths of the ports.
    typedef struct packed {
        logic                act;
        logic                line;
        logic [PIX_W-1:0]    a;
        logic [PIX_W-1:0]    b;
        logic [LVL_W-1:0]    cur;
        logic [LVL_W-1:0]    nxt;
        logic [TBL_AW-1:0]   idx;
        logic [FACTOR_W-1:0] val;
    } pix_req_t;

    typedef enum logic { ROW_REQUEST, ROW_REGISTER } row_kind_t;

    // Directed table row: a request, or a register write made while idle.
    // A typed pixel, where given, replaces the predicted one.
    typedef struct packed {
        row_kind_t            kind;
        pix_req_t             req;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [THR_W-1:0]     reg_val;
        logic                 has_typed;
        logic [PIX_W-1:0]     typed_pixel;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [THR_W-1:0]     cfg_wr_data;

    // Predictor state: its own copy of the table, switching state and registers.
    logic [FACTOR_W-1:0] level_factor [TBL_DEPTH];
    logic                decide_now;
    pend_t               queued_copy;
    cfg_t                active_cfg;

    logic [PIX_W-1:0] expected_pixels [$];
    dir_row_t         directed_rows [$];

    bit calm;  // no idling on either side in the closing phase
    int fault_count;
    int cycle_count;
    int table_writes;
    int mixed_pixels;
    int first_copies;
    int second_copies;
    int settings_used;

    rule_image_transition_blend_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // Per byte channel: wrapping difference times factor, keep bits 31..16,
    // double, add b, 16-bit mask, then bit 15 clears and overflow saturates.
    function automatic logic [PIX_W-1:0] mix_channels(logic [PIX_W-1:0] a,
                                                      logic [PIX_W-1:0] b,
                                                      logic [FACTOR_W-1:0] f);
        logic [31:0]      k;
        logic [31:0]      cb;
        logic [PIX_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < CH_N; ch++) begin
            cb = {24'd0, b[ch*CH_W +: CH_W]};
            k  = {24'd0, a[ch*CH_W +: CH_W]} - cb;
            k  = k * {16'd0, f};
            k  = ((k >> 16) << 1) + cb;
            k  = k & 32'h0000_FFFF;
            if (k[15]) begin
                k = '0;
            end else if (k > 32'd255) begin
                k = 32'd255;
            end
            r[ch*CH_W +: CH_W] = k[7:0];
        end
        return r;
    endfunction

    // Advances the predictor by one accepted request.
    task automatic step_model(input pix_req_t r, output bit gives, output logic [PIX_W-1:0] pix);
        logic [THR_W-1:0] cur9;
        logic [THR_W-1:0] nxt9;
        bit               mix;
        cur9  = {1'b0, r.cur};
        nxt9  = {1'b0, r.nxt};
        gives = 1'b0;
        pix   = '0;
        mix   = 1'b0;
        if (r.act == ACT_WRITE) begin
            level_factor[r.idx] = r.val;
            table_writes++;
        end else begin
            gives = 1'b1;
            if (r.line) begin
                decide_now  = 1'b1;
                queued_copy = PEND_NONE;
            end
            if (!active_cfg.switch_mode) begin
                mix = 1'b1;
            end else if (queued_copy == PEND_FIRST) begin
                // second pixel of a copied pair
                queued_copy = PEND_NONE;
                pix = r.a;
                first_copies++;
            end else if (queued_copy == PEND_SECOND) begin
                queued_copy = PEND_NONE;
                pix = r.b;
                second_copies++;
            end else if (decide_now) begin
                if (nxt9 >= active_cfg.first_level && cur9 < active_cfg.first_level) begin
                    decide_now = 1'b0;
                    mix = 1'b1;
                end else if (nxt9 >= active_cfg.first_level) begin
                    queued_copy = PEND_FIRST;
                    pix = r.a;
                    first_copies++;
                end else if (nxt9 >= active_cfg.second_level) begin
                    decide_now = 1'b0;
                    mix = 1'b1;
                end else if (cur9 >= active_cfg.second_level) begin
                    decide_now = 1'b0;
                    mix = 1'b1;
                end else begin
                    queued_copy = PEND_SECOND;
                    pix = r.b;
                    second_copies++;
                end
            end else begin
                decide_now = 1'b1;
                mix = 1'b1;
            end
            if (mix) begin
                pix = mix_channels(r.a, r.b, level_factor[r.cur]);
                mixed_pixels++;
            end
        end
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic logic [S_TDATA_W-1:0] pack_request(pix_req_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[TD_LINE]                = r.line;
        d[TD_A_LO   +: PIX_W]     = r.a;
        d[TD_B_LO   +: PIX_W]     = r.b;
        d[TD_CUR_LO +: LVL_W]     = r.cur;
        d[TD_NXT_LO +: LVL_W]     = r.nxt;
        d[TD_IDX_LO +: TBL_AW]    = r.idx;
        d[TD_VAL_LO +: FACTOR_W]  = r.val;
        return d;
    endfunction

    // Presents one request from a falling edge, with an occasional idle gap
    // first, and returns on the rising edge that takes it.
    task automatic issue_request(input pix_req_t r, input bit has_typed,
                                 input logic [PIX_W-1:0] typed);
        int               gap;
        bit               gives;
        logic [PIX_W-1:0] pix;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        s_tuser  <= r.act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_model(r, gives, pix);
        if (gives) begin
            expected_pixels.push_back(has_typed ? typed : pix);
        end
    endtask

    // Holds the sender until every expected pixel is back, then lets the
    // pipeline settle.
    task automatic wait_drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [THR_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_SWITCH_MODE:  active_cfg.switch_mode  = val[0];
            CFG_FIRST_LEVEL:  active_cfg.first_level  = val;
            CFG_SECOND_LEVEL: active_cfg.second_level = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------- directed table

    task automatic add_blend(input logic line, input logic [PIX_W-1:0] a,
                             input logic [PIX_W-1:0] b, input logic [LVL_W-1:0] cur,
                             input logic [LVL_W-1:0] nxt, input logic has_typed,
                             input logic [PIX_W-1:0] typed);
        dir_row_t row;
        row             = '0;
        row.kind        = ROW_REQUEST;
        row.req.act     = ACT_BLEND;
        row.req.line    = line;
        row.req.a       = a;
        row.req.b       = b;
        row.req.cur     = cur;
        row.req.nxt     = nxt;
        row.req.idx     = TBL_AW'($urandom);   // ignored by a blend
        row.req.val     = FACTOR_W'($urandom);
        row.has_typed   = has_typed;
        row.typed_pixel = typed;
        directed_rows.push_back(row);
    endtask

    task automatic add_write(input logic [TBL_AW-1:0] idx, input logic [FACTOR_W-1:0] val);
        dir_row_t row;
        row          = '0;
        row.kind     = ROW_REQUEST;
        row.req.act  = ACT_WRITE;
        row.req.line = 1'($urandom);      // a write ignores line start
        row.req.a    = $urandom;
        row.req.b    = $urandom;
        row.req.cur  = LVL_W'($urandom);
        row.req.nxt  = LVL_W'($urandom);
        row.req.idx  = idx;
        row.req.val  = val;
        directed_rows.push_back(row);
    endtask

    task automatic add_register(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_REGISTER;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed;
        // factors at the extremes, plus half and the smallest non-zero one
        add_write(8'd0,   16'h0000);
        add_write(8'd255, 16'hFFFF);
        add_write(8'd128, 16'h8000);
        add_write(8'd1,   16'h0001);
        // plain mode: a zero factor gives the second source unchanged
        add_blend(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0,   8'd255, 1'b1, 32'h0000_0000);
        add_blend(1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 8'd0,   8'd0,   1'b1, 32'h9ABC_DEF0);
        // full factor: a positive difference saturates every channel, a negative one clears it
        add_blend(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 8'd128, 1'b1, 32'hFFFF_FFFF);
        add_blend(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 8'd255, 8'd1,   1'b0, '0);
        // small negative difference with factor one: bit 15 set, channel cleared; then half factor
        add_blend(1'b0, 32'h0000_0000, 32'h0101_0101, 8'd1,   8'd0,   1'b1, 32'h0000_0000);
        add_blend(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 8'd128, 8'd255, 1'b0, '0);
        add_blend(1'b0, 32'h8080_8080, 32'h7F7F_7F7F, 8'd128, 8'd0,   1'b0, '0);
        // overwrite an entry, then read it back through a blend
        add_write(8'd255, 16'h0000);
        add_blend(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 8'd255, 8'd0,   1'b1, 32'h5555_5555);
        // switch mode, first level zero: every decision copies the first source
        add_register(CFG_SWITCH_MODE, 9'd1);
        add_register(CFG_FIRST_LEVEL, 9'd0);
        add_blend(1'b1, 32'h1111_1111, 32'h2222_2222, 8'd0, 8'd0, 1'b1, 32'h1111_1111);
        add_blend(1'b0, 32'h3333_3333, 32'h4444_4444, 8'd0, 8'd0, 1'b1, 32'h3333_3333);
        // levels above 256 behave as 256: nothing reaches them, so copy second
        add_register(CFG_FIRST_LEVEL,  9'd511);
        add_register(CFG_SECOND_LEVEL, 9'd511);
        add_blend(1'b1, 32'h5A5A_5A5A, 32'h6B6B_6B6B, 8'd255, 8'd255, 1'b1, 32'h6B6B_6B6B);
        add_blend(1'b0, 32'h7777_7777, 32'h8888_8888, 8'd255, 8'd255, 1'b1, 32'h8888_8888);
        // line start with no pair pending decides afresh
        add_blend(1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'd0,   8'd0,   1'b1, 32'hF0F0_F0F0);
        // the pending copy survives an idle register write
        add_register(CFG_SECOND_LEVEL, 9'd0);
        add_blend(1'b0, 32'hC3C3_C3C3, 32'h3C3C_3C3C, 8'd128, 8'd0,   1'b1, 32'h3C3C_3C3C);
        add_blend(1'b0, 32'h0123_4567, 32'h89AB_CDEF, 8'd128, 8'd0,   1'b0, '0);
        add_blend(1'b0, 32'hFEDC_BA98, 32'h7654_3210, 8'd128, 8'd1,   1'b0, '0);
    endtask

    // ---------------------------------------------------------------- random stimulus

    function automatic logic [PIX_W-1:0] random_pixel;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FACTOR_W-1:0] random_factor;
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return FACTOR_W'($urandom);
        endcase
    endfunction

    // Levels cluster around the two thresholds so the decisions are exercised.
    function automatic logic [LVL_W-1:0] pick_level(int first, int second);
        int v;
        int jitter;
        jitter = $urandom_range(0, 6);
        case ($urandom_range(0, 4))
            0:       v = first + jitter - 3;
            1:       v = second + jitter - 3;
            2:       v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[LVL_W-1:0];
    endfunction

    // One register setting: drain, write all three registers, then lines of
    // pixels whose next level matches the following pixel's level. About one
    // in ten pixels breaks the pattern, and one request in twelve is a write.
    task automatic run_phase(input bit mode, input int first, input int second, input int count);
        pix_req_t r;
        int       left;
        int       carry;
        wait_drain;
        write_register(CFG_SWITCH_MODE,  {8'd0, mode});
        write_register(CFG_FIRST_LEVEL,  first[THR_W-1:0]);
        write_register(CFG_SECOND_LEVEL, second[THR_W-1:0]);
        settings_used++;
        left  = 0;
        carry = 0;
        for (int n = 0; n < count; n++) begin
            r      = '0;
            r.a    = random_pixel();
            r.b    = random_pixel();
            r.idx  = TBL_AW'($urandom);
            r.val  = random_factor();
            if ($urandom_range(0, 11) == 0) begin
                r.act  = ACT_WRITE;
                r.line = 1'($urandom);
                r.cur  = LVL_W'($urandom);
                r.nxt  = LVL_W'($urandom);
            end else begin
                r.act = ACT_BLEND;
                if (left == 0) begin
                    left   = $urandom_range(1, 16);
                    r.line = 1'b1;
                    carry  = int'(pick_level(first, second));
                end
                r.cur = carry[LVL_W-1:0];
                r.nxt = pick_level(first, second);
                carry = int'(r.nxt);
                case ($urandom_range(0, 19))
                    0:       r.line = ~r.line;              // spurious or missing line start
                    1:       carry = $urandom_range(0, 255); // next level disagrees
                    default: ;
                endcase
                left--;
            end
            issue_request(r, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Back-pressure in occasional bursts, none in the closing phase.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && !calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // Each pixel taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("unexpected pixel %h with nothing outstanding", m_tdata);
                end
            end else if (m_tdata !== expected_pixels[0]) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("blended_pixel mismatch: expected %h, got %h",
                             expected_pixels[0], m_tdata);
                end
                void'(expected_pixels.pop_front());
            end else begin
                void'(expected_pixels.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, expected_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        pix_req_t r;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_BLEND;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_SWITCH_MODE;
        cfg_wr_data  = '0;
        aresetn      = 1'b0;
        calm         = 1'b0;
        fault_count  = 0;
        cycle_count  = 0;
        decide_now   = 1'b1;
        queued_copy  = PEND_NONE;
        active_cfg.switch_mode  = 1'b0;
        active_cfg.first_level  = FIRST_LEVEL_RST;
        active_cfg.second_level = SECOND_LEVEL_RST;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, from reset settings onwards.
        build_directed();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REGISTER) begin
                wait_drain;
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                issue_request(directed_rows[i].req, directed_rows[i].has_typed,
                              directed_rows[i].typed_pixel);
            end
        end

        // Load every table entry so that any rule level may be blended.
        for (int i = 0; i < TBL_DEPTH; i++) begin
            r     = '0;
            r.act = ACT_WRITE;
            r.line = 1'($urandom);
            r.a   = $urandom;
            r.b   = $urandom;
            r.cur = LVL_W'($urandom);
            r.nxt = LVL_W'($urandom);
            r.idx = i[TBL_AW-1:0];
            r.val = random_factor();
            issue_request(r, 1'b0, '0);
        end

        // Register settings, extremes among them.
        run_phase(1'b0, 256, 0,   110);
        run_phase(1'b1, 256, 0,   110);
        run_phase(1'b1, 128, 64,  110);
        run_phase(1'b1, 200, 40,  110);
        run_phase(1'b1, 0,   0,   100);
        run_phase(1'b1, 511, 511, 100);
        run_phase(1'b1, 256, 256, 100);
        run_phase(1'b1, 60,  180, 110);
        run_phase(1'b1, $urandom_range(0, 300), $urandom_range(0, 300), 110);
        run_phase(1'b0, 0,   511, 100);
        // closing phase at full rate on both sides
        wait_drain;
        calm = 1'b1;
        run_phase(1'b1, 140, 90,  160);

        wait_drain;
        $display("Covered %0d table writes, %0d blends, %0d first and %0d second copies,",
                 table_writes, mixed_pixels, first_copies, second_copies);
        $display("over %0d register settings in %0d cycles; %0d mismatches",
                 settings_used, cycle_count, fault_count);
        if (fault_count == 0 && expected_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rtb_pkg.sv
rtl/core/rtb_ram.sv
rtl/core/rtb_switch.sv
rtl/core/rtb_mix.sv
rtl/core/rule_image_transition_blend_top.sv
test/testbench.sv
